@@ src/fshc_pkg.sv @@
// fshc_pkg: shared types and constants of the fan step hysteresis controller
// used by fshc_ctrl, fshc_datapath and fan_step_hysteresis_controller_core
package fshc_pkg;

    localparam int LEVEL_W  = 3;   // fan level field
    localparam int TEMP_W   = 16;  // temperature samples
    localparam int THR_W    = 8;   // table thresholds
    localparam int RPM_W    = 16;  // target rpm
    localparam int WORD_W   = 48;  // one table entry
    localparam int CFG_IDX_W = 3;  // register index
    localparam int IN_W     = 32;  // input tdata: two samples
    localparam int OUT_W    = 24;  // output tdata: rpm, level, zero pad

    // table entry bit positions
    localparam int ON_CPU_LSB    = 0;
    localparam int ON_INLET_LSB  = 8;
    localparam int OFF_CPU_LSB   = 16;
    localparam int OFF_INLET_LSB = 24;
    localparam int RPM_LSB       = 32;

    // controller to datapath
    typedef struct packed {
        logic load;   // take a new sample pair
        logic step;   // move one level in the walk direction
        logic emit;   // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic move;   // the walk continues from the current level
    } t_stat;

endpackage

@@ src/fan_step_hysteresis_controller_core.sv @@
// fan_step_hysteresis_controller_core: top level of the fan step controller
// instantiates fshc_ctrl and fshc_datapath; depends on fshc_pkg
//
// usage
//   s_axis carries one item per sample pair: cpu_temp and inlet_temp, signed.
//   m_axis returns one item per input item: target fan_rpm and fan_level.
//   the cfg port writes the level table, one 48-bit entry per index; write
//   it only while the block is idle. indexes at or above LEVEL_COUNT are dropped.
// timing
//   an item is accepted, then the level walks one step per cycle
//   (up to LEVEL_COUNT-1 steps), then the output register is loaded. the walk
//   loops over the single table read port. s_axis_tready is high only
//   between items.
// reset and stall
//   synchronous reset clears the table, the level and the stored samples to 0.
//   the next item is accepted while a result waits in the output register; if
//   m_axis_tready stays low the walk holds at its end until the register frees.
module fan_step_hysteresis_controller_core #(
    parameter int LEVEL_COUNT = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [fshc_pkg::IN_W-1:0]         s_axis_tdata,   // cpu_temp, inlet_temp
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [fshc_pkg::OUT_W-1:0]        m_axis_tdata,   // fan_rpm, fan_level, pad
    input  logic                              i_cfg_we,
    input  logic [fshc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fshc_pkg::WORD_W-1:0]       i_cfg_data
);
    import fshc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    fshc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fshc_datapath #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample    (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[RPM_W +: LEVEL_W] <= LEVEL_W'(LEVEL_COUNT - 1)))
        else $error("fan level beyond table size");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while previous walk running");

    a_emit_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!stat.move && !cmd.step && !cmd.load))
        else $error("result loaded before walk finished");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> m_axis_tvalid)
        else $error("result loaded without output valid");
`endif

endmodule

@@ src/fshc_datapath.sv @@
// fshc_datapath: level table, current level, previous samples, threshold compare
// and result payload register; depends on fshc_pkg
module fshc_datapath #(
    parameter int LEVEL_COUNT = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fshc_pkg::t_cmd                      i_cmd,
    output fshc_pkg::t_stat                     o_stat,
    input  logic [fshc_pkg::IN_W-1:0]           i_sample,
    input  logic                                i_cfg_we,
    input  logic [fshc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fshc_pkg::WORD_W-1:0]         i_cfg_data,
    output logic [fshc_pkg::OUT_W-1:0]          o_result
);
    import fshc_pkg::*;

    localparam int IDX_W = $clog2(LEVEL_COUNT);
    localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(LEVEL_COUNT - 1);

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_UP,
        DIR_DOWN
    } t_dir;

    logic [WORD_W-1:0]        r_table [LEVEL_COUNT];
    logic [LEVEL_W-1:0]       r_level;
    logic signed [TEMP_W-1:0] r_cpu;
    logic signed [TEMP_W-1:0] r_inlet;
    t_dir                     r_dir;
    logic [OUT_W-1:0]         r_result;

    logic signed [TEMP_W-1:0] in_cpu;
    logic signed [TEMP_W-1:0] in_inlet;
    t_dir                     n_dir;
    logic [WORD_W-1:0]        entry;
    logic signed [TEMP_W-1:0] on_cpu, on_inlet, off_cpu, off_inlet;
    logic                     trig, rel;

    assign in_cpu   = i_sample[TEMP_W-1:0];
    assign in_inlet = i_sample[2*TEMP_W-1:TEMP_W];

    // direction follows the change against the previous sample pair
    always_comb begin
        if (in_cpu < r_cpu || in_inlet < r_inlet) begin
            n_dir = DIR_DOWN;
        end else if (in_cpu > r_cpu || in_inlet > r_inlet) begin
            n_dir = DIR_UP;
        end else begin
            n_dir = DIR_NONE;
        end
    end

    assign entry     = r_table[r_level[IDX_W-1:0]];
    assign on_cpu    = {{(TEMP_W-THR_W){entry[ON_CPU_LSB+THR_W-1]}},
                        entry[ON_CPU_LSB +: THR_W]};
    assign on_inlet  = {{(TEMP_W-THR_W){entry[ON_INLET_LSB+THR_W-1]}},
                        entry[ON_INLET_LSB +: THR_W]};
    assign off_cpu   = {{(TEMP_W-THR_W){entry[OFF_CPU_LSB+THR_W-1]}},
                        entry[OFF_CPU_LSB +: THR_W]};
    assign off_inlet = {{(TEMP_W-THR_W){entry[OFF_INLET_LSB+THR_W-1]}},
                        entry[OFF_INLET_LSB +: THR_W]};

    assign trig = (r_cpu > on_cpu) || (r_inlet > on_inlet);
    assign rel  = (r_cpu < off_cpu) && (r_inlet < off_inlet);

    // a trigger at the top level clamps there, so the walk simply ends
    always_comb begin
        case (r_dir)
            DIR_UP:   o_stat.move = trig && (r_level != LAST_LEVEL);
            DIR_DOWN: o_stat.move = rel && (r_level != '0);
            default:  o_stat.move = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LEVEL_COUNT; k++) begin
                r_table[k] <= '0;
            end
            r_level <= '0;
            r_cpu   <= '0;
            r_inlet <= '0;
            r_dir   <= DIR_NONE;
        end else begin
            // entries above the table size are never read
            if (i_cfg_we && ({1'b0, i_cfg_index} < (CFG_IDX_W+1)'(LEVEL_COUNT))) begin
                r_table[i_cfg_index[IDX_W-1:0]] <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_dir   <= n_dir;
                r_cpu   <= in_cpu;
                r_inlet <= in_inlet;
            end
            if (i_cmd.step) begin
                if (r_dir == DIR_UP) begin
                    r_level <= r_level + LEVEL_W'(1);
                end else begin
                    r_level <= r_level - LEVEL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_result <= {(OUT_W-RPM_W-LEVEL_W)'(0), r_level, entry[RPM_LSB +: RPM_W]};
        end
    end

    assign o_result = r_result;

endmodule

@@ src/fshc_ctrl.sv @@
// fshc_ctrl: state machine that sequences accept, level walk and result handoff
// depends on fshc_pkg
module fshc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  fshc_pkg::t_stat  i_stat,
    output fshc_pkg::t_cmd   o_cmd
);
    import fshc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_stat.move) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    // walk finished: hand the item to the output register
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench of fan_step_hysteresis_controller_core
// drives sample pairs and level-table writes, predicts rpm and level; needs fshc_pkg

typedef struct packed {
    logic [15:0] rpm;
    logic [2:0]  level;
} t_fan_result;

class fan_level_scoreboard;
    int                 n_levels;
    logic [47:0]        level_word [8];
    logic [2:0]         level_now;
    logic signed [15:0] prev_cpu;
    logic signed [15:0] prev_inlet;
    t_fan_result        expected_q [$];
    int                 n_fail;

    function new(int levels);
        n_levels   = levels;
        level_now  = '0;
        prev_cpu   = '0;
        prev_inlet = '0;
        n_fail     = 0;
        foreach (level_word[k]) level_word[k] = '0;
    endfunction

    function void set_word(int idx, logic [47:0] w);
        level_word[idx & 7] = w;
    endfunction

    function logic signed [7:0] thr(int lvl, int lsb);
        return level_word[lvl][lsb +: 8];
    endfunction

    // walk the level for one accepted sample pair and queue the result
    function void note_sample(logic signed [15:0] cpu, logic signed [15:0] inl);
        int          lvl;
        int          i;
        t_fan_result res;
        lvl = level_now;
        if (lvl > n_levels - 1) lvl = n_levels - 1;
        if (cpu < prev_cpu || inl < prev_inlet) begin
            for (i = lvl; i > 0; i--) begin
                if (cpu < thr(i, fshc_pkg::OFF_CPU_LSB) &&
                    inl < thr(i, fshc_pkg::OFF_INLET_LSB)) begin
                    lvl = i - 1;
                end else begin
                    break;
                end
            end
        end else if (cpu > prev_cpu || inl > prev_inlet) begin
            for (i = lvl; i < n_levels; i++) begin
                if (cpu > thr(i, fshc_pkg::ON_CPU_LSB) ||
                    inl > thr(i, fshc_pkg::ON_INLET_LSB)) begin
                    lvl = i + 1;
                end else begin
                    break;
                end
            end
        end
        if (lvl > n_levels - 1) lvl = n_levels - 1;
        level_now  = lvl[2:0];
        prev_cpu   = cpu;
        prev_inlet = inl;
        res.rpm    = level_word[lvl][fshc_pkg::RPM_LSB +: 16];
        res.level  = lvl[2:0];
        expected_q.push_back(res);
    endfunction

    function void check_result(logic [15:0] rpm, logic [2:0] level);
        t_fan_result exp_res;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result rpm %h level %0d", $time, rpm, level);
            n_fail++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (rpm !== exp_res.rpm) begin
            $display("%0t: fan_rpm expected %h got %h", $time, exp_res.rpm, rpm);
            n_fail++;
        end
        if (level !== exp_res.level) begin
            $display("%0t: fan_level expected %0d got %0d", $time, exp_res.level, level);
            n_fail++;
        end
    endfunction
endclass

module tb_top;
    import fshc_pkg::*;

    localparam int LEVEL_COUNT  = 8;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 366;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;    // cpu_temp, inlet_temp
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;    // fan_rpm, fan_level, pad
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [WORD_W-1:0]    i_cfg_data;

    fan_level_scoreboard sb = new(LEVEL_COUNT);

    bit idle_on;
    bit hold_req;
    int cur_cpu;
    int cur_inlet;

    fan_step_hysteresis_controller_core #(.LEVEL_COUNT(LEVEL_COUNT)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_sample(s_axis_tdata[15:0], s_axis_tdata[31:16]);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata[15:0], m_axis_tdata[18:16]);
        end
    end

    // ends the run when no item moves on either side for too long
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            gap = idle_on ? $urandom_range(0, 18) : 0;
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    function automatic logic [47:0] make_word(logic [7:0] on_c, logic [7:0] on_i,
                                              logic [7:0] off_c, logic [7:0] off_i,
                                              logic [15:0] rpm);
        return {rpm, off_i, off_c, on_i, on_c};
    endfunction

    // called at a falling edge
    task automatic write_level(int idx, logic [47:0] w);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx[CFG_IDX_W-1:0];
        i_cfg_data  = w;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_word(idx, w);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_sample(logic [15:0] cpu, logic [15:0] inl);
        int gap;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {inl, cpu};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.expected_q.size() > 0) @(negedge i_clk);
        repeat (LEVEL_COUNT + 2) @(negedge i_clk);
    endtask

    // thresholds climb with the level, release a bit below trigger
    task automatic write_staircase(bit rand_rpm);
        int   k;
        int   on_c;
        int   on_i;
        logic [15:0] rpm;
        for (k = 0; k < 8; k++) begin
            on_c = -40 + 15 * k;
            on_i = -30 + 15 * k;
            rpm  = rand_rpm ? 16'($urandom) : 16'(1000 * k + 500);
            write_level(k, make_word(8'(on_c), 8'(on_i), 8'(on_c - 8), 8'(on_i - 8), rpm));
        end
    endtask

    function automatic int clamp_temp(int v);
        if (v > 160) return 160;
        if (v < -160) return -160;
        return v;
    endfunction

    // mostly a slow drift around the threshold range, with jumps and repeats
    task automatic run_random(int count);
        int n;
        int r;
        for (n = 0; n < count; n++) begin
            r = $urandom_range(0, 19);
            if (r < 2) begin
                cur_cpu   = int'($signed(16'($urandom)));
                cur_inlet = int'($signed(16'($urandom)));
            end else if (r < 4) begin
                // repeat the previous pair
            end else if (r < 6) begin
                if ($urandom_range(0, 1))
                    cur_cpu = clamp_temp(cur_cpu + $urandom_range(0, 16) - 8);
                else
                    cur_inlet = clamp_temp(cur_inlet + $urandom_range(0, 16) - 8);
            end else begin
                cur_cpu   = clamp_temp(cur_cpu + $urandom_range(0, 16) - 8);
                cur_inlet = clamp_temp(cur_inlet + $urandom_range(0, 16) - 8);
            end
            send_sample(16'(cur_cpu), 16'(cur_inlet));
        end
    endtask

    initial begin
        int k;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        cur_cpu       = 0;
        cur_inlet     = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // all-zero table after reset
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h0001, 16'h0000);
        send_sample(16'h0001, 16'h0000);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
        drain();

        write_staircase(1'b0);
        send_sample(16'h7FFF, 16'h0000);
        send_sample(16'h7FFF, 16'h0000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFEC, 16'hFFEC);
        send_sample(16'hFFFF, 16'h0001);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555);
        send_sample(16'h0001, 16'hFFFF);
        send_sample(16'h0000, 16'h7FFF);
        send_sample(16'h0000, 16'h8000);
        run_random(RANDOM_ITEMS);
        drain();

        for (k = 0; k < 8; k++) write_level(k, 48'({$urandom, $urandom}));
        run_random(RANDOM_ITEMS);
        drain();

        // thresholds at the far ends: hardly any movement
        for (k = 0; k < 7; k++) begin
            write_level(k, make_word(8'h7F, 8'h7F, 8'h80, 8'h80,
                                     (k % 2) ? 16'h0000 : 16'hFFFF));
        end
        write_level(7, 48'hFFFF_FFFF_FFFF);
        run_random(RANDOM_ITEMS);
        drain();

        // opposite ends: most changes walk the full table, no stalls
        idle_on = 1'b0;
        for (k = 0; k < 8; k++) begin
            write_level(k, make_word(8'h80, 8'h80, 8'h7F, 8'h7F, 16'($urandom)));
        end
        run_random(RANDOM_ITEMS);
        drain();

        // long output hold-off while the input keeps offering items
        idle_on  = 1'b1;
        write_staircase(1'b1);
        hold_req = 1'b1;
        run_random(RANDOM_ITEMS);
        drain();

        repeat (LEVEL_COUNT + 4) @(posedge i_clk);
        if (sb.n_fail == 0 && sb.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
